[src/spq_pkg.sv]
// Shared types and constants for the sorted priority queue.
// Used by spq_ctrl, spq_dpath and sorted_priority_queue; no dependencies.
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int REC_W       = 48;
    localparam int S_DATA_W    = 48;
    localparam int S_USER_W    = 1;
    localparam int M_DATA_W    = 56;
    localparam int M_USER_W    = 3;

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Record layout, id in the lowest bits.
    typedef struct packed {
        logic [15:0] service;
        logic [15:0] arrival;
        logic [7:0]  pri;
        logic [7:0]  id;
    } t_rec;

    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // apply it to the queue and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;  // result register holds an item not taken this cycle
    } t_dp_stat;

endpackage

[src/spq_ctrl.sv]
// Controller of the sorted priority queue: two-state sequencer.
// Depends on spq_pkg.
module spq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  spq_pkg::t_dp_stat  i_stat,
    output logic               o_s_ready,
    output spq_pkg::t_dp_cmd   o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state    = r_state;
        o_s_ready  = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
                if (i_s_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // Wait until the result register can take the new result.
                if (!i_stat.out_busy) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[src/spq_dpath.sv]
// Datapath of the sorted priority queue: sorted cells, count and result register.
// Depends on spq_pkg.
module spq_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  spq_pkg::t_dp_cmd               i_cmd,
    output spq_pkg::t_dp_stat              o_stat,
    input  logic                           i_op,
    input  spq_pkg::t_rec                  i_rec,
    input  logic                           i_m_ready,
    output logic                           o_m_valid,
    output logic [spq_pkg::M_DATA_W-1:0]   o_m_data,
    output logic [spq_pkg::M_USER_W-1:0]   o_m_user
);

    localparam int D = spq_pkg::QUEUE_DEPTH;

    logic                      r_op;
    spq_pkg::t_rec             r_in;
    spq_pkg::t_rec             r_entries [D];
    spq_pkg::t_rec             n_entries [D];
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic [D-1:0]              le;
    logic                      full;
    logic                      empty;
    logic                      write_en;

    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic                      r_rec_valid;
    spq_pkg::t_rec             r_rec;
    logic [spq_pkg::OCC_W-1:0] r_occ;
    logic [1:0]                n_status;
    logic                      n_rec_valid;
    spq_pkg::t_rec             n_rec;

    assign full  = (r_count == spq_pkg::CNT_W'(D));
    assign empty = (r_count == '0);

    // Each cell compares its own priority with the incoming one; since the
    // cells are sorted, the set of cells that stay put is a prefix.
    always_comb begin
        for (int k = 0; k < D; k++) begin
            le[k] = (spq_pkg::CNT_W'(k) < r_count) && (r_entries[k].pri <= r_in.pri);
        end
        for (int k = 0; k < D; k++) begin
            if (r_op == spq_pkg::OP_PUSH) begin
                if (le[k]) begin
                    n_entries[k] = r_entries[k];
                end else if (k == 0) begin
                    n_entries[k] = r_in;
                end else if (le[k-1]) begin
                    n_entries[k] = r_in;
                end else begin
                    n_entries[k] = r_entries[k-1];
                end
            end else begin
                if (k == D - 1) begin
                    n_entries[k] = r_entries[k];
                end else begin
                    n_entries[k] = r_entries[k+1];
                end
            end
        end
    end

    always_comb begin
        write_en    = 1'b0;
        n_count     = r_count;
        n_status    = spq_pkg::ST_OK;
        n_rec_valid = 1'b1;
        n_rec       = r_entries[0];
        if (r_op == spq_pkg::OP_PUSH) begin
            if (full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                write_en = 1'b1;
                n_count  = r_count + spq_pkg::CNT_W'(1);
                n_rec    = le[0] ? r_entries[0] : r_in;
            end
        end else begin
            if (empty) begin
                n_status    = spq_pkg::ST_EMPTY;
                n_rec_valid = 1'b0;
                n_rec       = '0;
            end else begin
                write_en = 1'b1;
                n_count  = r_count - spq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_in <= i_rec;
        end
        if (i_cmd.exec && write_en) begin
            for (int k = 0; k < D; k++) begin
                r_entries[k] <= n_entries[k];
            end
        end
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_rec_valid <= n_rec_valid;
            r_rec       <= n_rec;
            r_occ       <= spq_pkg::OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_out_valid && !i_m_ready;
    assign o_m_valid       = r_out_valid;
    assign o_m_data        = {3'b000, r_occ, r_rec};
    assign o_m_user        = {r_rec_valid, r_status};

endmodule

[src/sorted_priority_queue.sv]
// Sorted priority queue: an accepted item is first captured, then applied to
// the sorted cells while the result register is loaded, once it is free.
// No new item is taken before the last one is applied (two-state controller).
// A result waiting at the output does not block acceptance of the next item.
// Reset (synchronous, active low) empties the queue and the result register;
// the record cells are not cleared, since only entries below the count are read.
module sorted_priority_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // Fields from bit 0: rec_id[7:0], rec_priority[15:8], rec_arrival[31:16],
    // rec_service[47:32].
    input  logic [spq_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // Fields from bit 0: operation[0] (0 push, 1 pop).
    input  logic [spq_pkg::S_USER_W-1:0] i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // Fields from bit 0: out_id[7:0], out_priority[15:8], out_arrival[31:16],
    // out_service[47:32], occupancy[52:48], zero padding[55:53].
    output logic [spq_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // Fields from bit 0: status[1:0], out_valid[2].
    output logic [spq_pkg::M_USER_W-1:0] o_m_axis_tuser
);

    spq_pkg::t_dp_cmd  cmd;
    spq_pkg::t_dp_stat stat;
    spq_pkg::t_rec     in_rec;

    // The input record is laid out exactly as the record type.
    assign in_rec = spq_pkg::t_rec'(i_s_axis_tdata[spq_pkg::REC_W-1:0]);

    // The controller only sequences capture and execution; it never sees
    // payload. The datapath holds the sorted cells, where every cell decides
    // in parallel whether to hold, take the new record or take its neighbor.
    spq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_stat    (stat),
        .o_s_ready (o_s_axis_tready),
        .o_cmd     (cmd)
    );

    spq_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_stat    (stat),
        .i_op      (i_s_axis_tuser[0]),
        .i_rec     (in_rec),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_m_data  (o_m_axis_tdata),
        .o_m_user  (o_m_axis_tuser)
    );

    // An empty-queue pop never reports a record.
    a_empty_no_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1:0] == spq_pkg::ST_EMPTY)
            |-> (o_m_axis_tuser[2] == 1'b0 && o_m_axis_tdata[52:48] == '0))
        else $error("pop on empty reported a record or nonzero occupancy");

    // A dropped push only happens on a full queue.
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[1:0] == spq_pkg::ST_FULL)
            |-> (o_m_axis_tdata[52:48] == spq_pkg::OCC_W'(spq_pkg::QUEUE_DEPTH)))
        else $error("push dropped while queue not full");

    // Occupancy never exceeds the depth.
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid
            |-> (o_m_axis_tdata[52:48] <= spq_pkg::OCC_W'(spq_pkg::QUEUE_DEPTH)))
        else $error("occupancy beyond depth");

    // One item in flight: after an accept, no new item is taken next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("item accepted while previous item still executing");

endmodule

[tb/spq_scoreboard_pkg.sv]
// Scoreboard for the sorted priority queue: a mirror of the sorted record list
// that predicts each result item and checks what the block returns.
// Depends on spq_pkg for the record layout, codes and widths.
package spq_scoreboard_pkg;

    typedef struct {
        logic [1:0]                status;
        logic                      head_valid;
        spq_pkg::t_rec             rec;
        logic [spq_pkg::OCC_W-1:0] occ;
    } t_head_report;

    class spq_queue_mirror;

        spq_pkg::t_rec cells [spq_pkg::QUEUE_DEPTH];
        int unsigned   fill;
        t_head_report  awaited_heads [$];
        int unsigned   errors;
        int unsigned   pushes;
        int unsigned   dropped_pushes;
        int unsigned   pops;
        int unsigned   empty_pops;
        int unsigned   results_checked;

        function new();
            fill            = 0;
            errors          = 0;
            pushes          = 0;
            dropped_pushes  = 0;
            pops            = 0;
            empty_pops      = 0;
            results_checked = 0;
        endfunction

        function int unsigned pending();
            return awaited_heads.size();
        endfunction

        // Apply one accepted item to the mirror and queue the result it causes.
        function void note_item(logic op, spq_pkg::t_rec r);
            t_head_report rep;
            int unsigned  pos;
            int unsigned  k;
            rep.status     = spq_pkg::ST_OK;
            rep.head_valid = 1'b1;
            rep.rec        = '0;
            if (op == spq_pkg::OP_PUSH) begin
                pushes++;
                if (fill >= spq_pkg::QUEUE_DEPTH) begin
                    rep.status = spq_pkg::ST_FULL;
                    dropped_pushes++;
                end else begin
                    // Equal priorities stay in arrival order, so skip past them.
                    pos = 0;
                    while (pos < fill && cells[pos].pri <= r.pri)
                        pos++;
                    for (k = fill; k > pos; k--)
                        cells[k] = cells[k-1];
                    cells[pos] = r;
                    fill++;
                end
                rep.rec = cells[0];
            end else begin
                pops++;
                if (fill == 0) begin
                    rep.status     = spq_pkg::ST_EMPTY;
                    rep.head_valid = 1'b0;
                    empty_pops++;
                end else begin
                    rep.rec = cells[0];
                    for (k = 1; k < fill; k++)
                        cells[k-1] = cells[k];
                    fill--;
                end
            end
            rep.occ = spq_pkg::OCC_W'(fill);
            awaited_heads.push_back(rep);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t ERROR %s: expected 0x%0h, actual 0x%0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result item with the oldest prediction.
        function void check_result(logic [spq_pkg::M_DATA_W-1:0] d,
                                   logic [spq_pkg::M_USER_W-1:0] u);
            t_head_report want;
            if (awaited_heads.size() == 0) begin
                $display("%0t ERROR result item with nothing outstanding: tdata 0x%0h tuser 0x%0h",
                         $time, d, u);
                errors++;
                return;
            end
            want = awaited_heads.pop_front();
            results_checked++;
            compare_field("status",       want.status,      u[1:0]);
            compare_field("out_valid",    want.head_valid,  u[2]);
            compare_field("out_id",       want.rec.id,      d[7:0]);
            compare_field("out_priority", want.rec.pri,     d[15:8]);
            compare_field("out_arrival",  want.rec.arrival, d[31:16]);
            compare_field("out_service",  want.rec.service, d[47:32]);
            compare_field("occupancy",    want.occ,         d[52:48]);
        endfunction

    endclass

endpackage

[tb/tb_sorted_priority_queue.sv]
// Self-checking testbench for sorted_priority_queue: directed and random push/pop
// items with random idling on both stream sides, checked against a queue mirror.
// Depends on spq_pkg and spq_scoreboard_pkg.
module tb_sorted_priority_queue;

    localparam int          LONG_HOLD   = 80;
    localparam int          N_PHASES    = 16;
    localparam int          PHASE_ITEMS = 100;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [spq_pkg::S_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic [spq_pkg::S_USER_W-1:0]  i_s_axis_tuser  = '0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [spq_pkg::M_DATA_W-1:0]  o_m_axis_tdata;
    logic [spq_pkg::M_USER_W-1:0]  o_m_axis_tuser;

    spq_scoreboard_pkg::spq_queue_mirror mirror = new();

    // Receiver control, shared between the stimulus and the receiver process.
    bit          rx_steady     = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned cycles        = 0;

    sorted_priority_queue u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both handshakes are sampled at the rising edge, before any register update
    // of that edge lands. A result can never belong to an item accepted at the
    // same edge, so checking first and noting the new item second is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                mirror.check_result(o_m_axis_tdata, o_m_axis_tuser);
            if (i_s_axis_tvalid && o_s_axis_tready)
                mirror.note_item(i_s_axis_tuser[0], spq_pkg::t_rec'(i_s_axis_tdata));
        end
    end

    // Receiver: random stall bursts, an always-ready mode, and on request one long
    // hold-off that lets the block back up into its input.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    i_m_axis_tready <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                stall_left = LONG_HOLD;
            end else if (!rx_steady && $urandom_range(0, 5) == 0) begin
                i_m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 5);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // The run is bounded by a cycle count far above the slowest correct run.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t timeout after %0d cycles", $time, cycles);
        $display("FAIL");
        $finish;
    end

    // A sender gap: most items follow at once, some after an idle burst of random length.
    function automatic int pick_gap(bit idle);
        if (idle && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 5);
        return 0;
    endfunction

    // Random record. The priority mode decides how often priorities collide:
    // full range, a tiny range full of ties, the extremes, or a narrow middle band.
    function automatic spq_pkg::t_rec make_record(int pri_mode);
        spq_pkg::t_rec r;
        r.id = 8'($urandom_range(0, 255));
        case (pri_mode)
            0: r.pri = 8'($urandom_range(0, 255));
            1: r.pri = 8'($urandom_range(0, 3));
            2: begin
                case ($urandom_range(0, 3))
                    0: r.pri = 8'd0;
                    1: r.pri = 8'd1;
                    2: r.pri = 8'd254;
                    default: r.pri = 8'd255;
                endcase
            end
            default: r.pri = 8'($urandom_range(100, 108));
        endcase
        r.arrival = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
        r.service = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom);
        return r;
    endfunction

    // Offer one item and hold it until the block takes it. With no gap, valid is
    // left high so the next call can present its item in the same time step.
    task automatic send_item(input logic op, input spq_pkg::t_rec r, input int gap);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= r;
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every predicted result item has come back.
    // The first check waits for a rising edge, so the item accepted last is already in the mirror.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (mirror.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(int n_items, int push_pct, int pri_mode, bit idle);
        logic          op;
        spq_pkg::t_rec r;
        for (int i = 0; i < n_items; i++) begin
            op = ($urandom_range(1, 100) <= push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
            r  = make_record(pri_mode);
            send_item(op, r, pick_gap(idle));
        end
    endtask

    initial begin : stimulus
        spq_pkg::t_rec r;
        int   push_pct [N_PHASES] = '{80, 50, 20, 95, 70, 50, 30, 90,
                                      60, 10, 85, 50, 75, 40, 90, 30};
        bit   idle;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. A pop on the empty queue must report empty with no record.
        send_item(spq_pkg::OP_POP, make_record(0), pick_gap(1));

        // Extremes of every field, then a second record at each extreme priority.
        // The later arrival at equal priority must leave after the earlier one.
        r = '0;
        send_item(spq_pkg::OP_PUSH, r, 0);
        r = '1;
        send_item(spq_pkg::OP_PUSH, r, pick_gap(1));
        r = '{service: 16'h5A5A, arrival: 16'hA5A5, pri: 8'd255, id: 8'h11};
        send_item(spq_pkg::OP_PUSH, r, 0);
        r = '{service: 16'h0F0F, arrival: 16'hF0F0, pri: 8'd0, id: 8'h22};
        send_item(spq_pkg::OP_PUSH, r, 0);
        send_item(spq_pkg::OP_POP, make_record(0), 0);
        send_item(spq_pkg::OP_POP, make_record(0), pick_gap(1));

        // Fill the queue to capacity, push once more into the full queue (dropped),
        // then take the head.
        for (int k = 0; k < spq_pkg::QUEUE_DEPTH - 2; k++) begin
            r     = make_record(0);
            r.pri = 8'(k * 19);
            send_item(spq_pkg::OP_PUSH, r, pick_gap(1));
        end
        send_item(spq_pkg::OP_PUSH, make_record(2), 0);
        send_item(spq_pkg::OP_POP, make_record(0), 0);
        drain_results();

        // Random part in phases. Each phase has its own push share, so the queue
        // swings between empty and full, and its own priority mix for ties.
        // Phase 4 also asks the receiver for one long hold-off while items keep
        // coming. Between phases the sender pauses until all results are in.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            idle      = !(ph == 7 || ph >= N_PHASES - 2);
            rx_steady = !idle;
            if (ph == 4)
                long_hold_req = 1'b1;
            random_phase(PHASE_ITEMS, push_pct[ph], ph % 4, idle);
            drain_results();
        end

        repeat (10) @(posedge i_clk);

        $display("Run covered %0d pushes (%0d dropped on a full queue) and %0d pops (%0d on empty).",
                 mirror.pushes, mirror.dropped_pushes, mirror.pops, mirror.empty_pops);
        $display("%0d result items checked, %0d mismatches, %0d cycles.",
                 mirror.results_checked, mirror.errors, cycles);
        if (mirror.errors == 0 && mirror.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_dpath.sv
src/sorted_priority_queue.sv
tb/spq_scoreboard_pkg.sv
tb/tb_sorted_priority_queue.sv
